// File: design/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the Mandelbrot escape-time pixel unit
// Fixed-point format, register indexes, controller states, datapath commands
// and the saturating helper used by the datapath.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// Fixed-point word: signed, FRAC_BITS fraction bits (Q4.28).
	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 28;

	// Iteration limit of the loop counter (the shade still divides by max_iter).
	localparam logic [7:0] ITER_LIMIT = 8'd255;

	// Screen centre that the pixel coordinates are taken relative to.
	localparam logic signed [9:0] CENTRE_X = 10'sd160;
	localparam logic signed [8:0] CENTRE_Y = 9'sd100;

	// Escape bound |z|^2 < 4.0 in the fixed-point format.
	localparam logic signed [WORD_W-1:0] ESCAPE_BOUND = 32'sd4 <<< FRAC_BITS;

	// Reset value of the iteration limit register.
	localparam logic [7:0] MAX_ITER_RESET = 8'd32;

	// Width of the sums handed to the saturating helper.
	localparam int SAT_IN_W = 66;

	// Shade divider operand widths.
	localparam int DIV_NUM_W = 16;
	localparam int DIV_CNT_W = 4;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_ITER   = 2'd0;
	localparam logic [1:0] REG_ORIGIN_X   = 2'd1;
	localparam logic [1:0] REG_ORIGIN_Y   = 2'd2;
	localparam logic [1:0] REG_PIXEL_STEP = 2'd3;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RE,
		ST_MUL_IM,
		ST_INIT,
		ST_CHECK,
		ST_SQ_X,
		ST_SQ_Y,
		ST_ACC,
		ST_DIV,
		ST_FINISH
	} ctrl_state_t;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL_RE,     // product <= dcol * step
		OP_MUL_IM,     // c_re <= sat(product) + origin_x, product <= drow * step
		OP_INIT,       // c_im <= sat(product) + origin_y, clear z and count
		OP_ITER_XY,    // product <= x*y, x <= c_re + x2 - y2
		OP_ITER_SQX,   // y <= c_im + 2xy, product <= x*x
		OP_ITER_SQY,   // x2 <= x*x, product <= y*y
		OP_ITER_ACC,   // y2 <= y*y, count++
		OP_DIV_START,  // start the shade division
		OP_SHADE,      // shade <= quotient
		OP_ZERO_SHADE  // shade <= 0
	} dp_op_t;

	typedef struct packed {
		logic   load_pixel;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic iter_go;
		logic count_ge2;
		logic div_done;
	} dp_status_t;

	// Clamp a wide signed value to the fixed-point word range.
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = SAT_IN_W'(32'sh7fff_ffff);
		lo = SAT_IN_W'(-33'sd2147483648);
		if (v > hi) begin
			sat_word = 32'sh7fff_ffff;
		end else if (v < lo) begin
			sat_word = 32'sh8000_0000;
		end else begin
			sat_word = v[WORD_W-1:0];
		end
	endfunction

endpackage

// File: design/mandelbrot_escape_time_pixel_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit: escape-time evaluator for one pixel
// Maps a pixel to a point of the complex plane, iterates z = z^2 + c and
// returns the iteration count and a grey shade.
// ----------------------------------------------------------------------------
// Usage:
// Load max_iter, origin_x, origin_y and pixel_step through the write port
// (cfg_we, cfg_index, cfg_data) while the unit is idle. A pixel transfer
// happens at a rising edge with start high and busy low; column and
// pixel_row are captured then. The result (shade, iteration_count) is shown
// for exactly one cycle with done high and must be taken in that cycle.
// The iteration uses one 32x32 multiplier with a registered product, shared
// by x*y, x*x and y*y; the shade then comes from a one-bit-per-cycle
// divider, whose quotient is stored, or is zero for a count below two.
// One pixel is in flight at a time; the next one may start in the cycle
// after done. Reset sets max_iter to 32, the other configuration
// registers to zero, and leaves the unit idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [8:0]  column,
	input  logic [7:0]  pixel_row,
	output logic        done,
	output logic [7:0]  shade,
	output logic [7:0]  iteration_count
);

	mbe_pkg::dp_cmd_t    cmd;
	mbe_pkg::dp_status_t status;

	mbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mbe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.column          (column),
		.pixel_row       (pixel_row),
		.cmd             (cmd),
		.status          (status),
		.shade           (shade),
		.iteration_count (iteration_count)
	);

	// A result strobe only comes while the unit is still marked busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done raised while idle");

	// The result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// A pixel transfer makes the unit busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("pixel transfer did not start the unit");

	// A count below two always comes with a black shade.
	a_low_count_black: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((shade == 8'd0) || (iteration_count >= 8'd2)))
		else $error("nonzero shade for a count below two");

endmodule

// File: design/mbe_div.sv
// ----------------------------------------------------------------------------
// mbe_div: restoring divider for the shade
// Divides a 16-bit dividend by an 8-bit divisor, one quotient bit per cycle.
// Only the low eight quotient bits are kept; the shade never exceeds 255.
// ----------------------------------------------------------------------------
module mbe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mbe_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [7:0]                    divisor,
	output logic [7:0]                    quotient,
	output logic                          done
);

	logic                          active_q;
	logic                          done_q;
	logic [mbe_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [mbe_pkg::DIV_NUM_W-1:0] num_q;
	logic [7:0]                    div_q;
	logic [7:0]                    rem_q;
	logic [7:0]                    quo_q;
	logic [8:0]                    trial;
	logic [8:0]                    diff;
	logic                          fits;

	// Trial subtraction of one step.
	always_comb begin
		trial = {rem_q, num_q[mbe_pkg::DIV_NUM_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {mbe_pkg::DIV_CNT_W{1'b1}}) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (active_q) begin
			num_q <= {num_q[mbe_pkg::DIV_NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[6:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: design/mbe_dp.sv
// ----------------------------------------------------------------------------
// mbe_dp: datapath of the escape-time unit
// Holds the configuration registers, the complex point, the iterate z, its
// squares and the count. One shared 32x32 multiplier with a registered
// product serves every product; the shade divider hangs off the count.
// ----------------------------------------------------------------------------
module mbe_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic [8:0]                  column,
	input  logic [7:0]                  pixel_row,
	input  mbe_pkg::dp_cmd_t            cmd,
	output mbe_pkg::dp_status_t         status,
	output logic [7:0]                  shade,
	output logic [7:0]                  iteration_count
);

	localparam int W  = mbe_pkg::WORD_W;
	localparam int SW = mbe_pkg::SAT_IN_W;

	// Configuration registers.
	logic [7:0]            max_iter_q;
	logic signed [W-1:0]   origin_x_q;
	logic signed [W-1:0]   origin_y_q;
	logic [W-2:0]          pixel_step_q;

	// Working registers.
	logic [8:0]            col_q;
	logic [7:0]            row_q;
	logic signed [W-1:0]   c_re_q;
	logic signed [W-1:0]   c_im_q;
	logic signed [W-1:0]   x_q;
	logic signed [W-1:0]   y_q;
	logic signed [W-1:0]   x2_q;
	logic signed [W-1:0]   y2_q;
	logic signed [2*W-1:0] prod_q;
	logic [7:0]            count_q;
	logic [7:0]            shade_q;

	logic signed [9:0]     dcol;
	logic signed [8:0]     drow;
	logic signed [W-1:0]   mul_a;
	logic signed [W-1:0]   mul_b;
	logic                  mul_en;
	logic signed [W-1:0]   prod_sat;
	logic signed [W-1:0]   next_x;
	logic signed [W-1:0]   next_y;
	logic signed [W-1:0]   sq_word;
	logic signed [W-1:0]   mag_sq;
	logic [7:0]            limit;
	logic [mbe_pkg::DIV_NUM_W-1:0] scaled_count;
	logic [7:0]            quotient;
	logic                  div_done;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q   <= mbe_pkg::MAX_ITER_RESET;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			pixel_step_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbe_pkg::REG_MAX_ITER:   max_iter_q   <= cfg_data[7:0];
				mbe_pkg::REG_ORIGIN_X:   origin_x_q   <= $signed(cfg_data);
				mbe_pkg::REG_ORIGIN_Y:   origin_y_q   <= $signed(cfg_data);
				mbe_pkg::REG_PIXEL_STEP: pixel_step_q <= cfg_data[W-2:0];
				default:                 max_iter_q   <= max_iter_q;
			endcase
		end
	end

	// Pixel offsets from the screen centre.
	always_comb begin
		dcol = $signed({1'b0, col_q}) - mbe_pkg::CENTRE_X;
		drow = $signed({1'b0, row_q}) - mbe_pkg::CENTRE_Y;
	end

	// Multiplier operand selection.
	always_comb begin
		mul_a  = x_q;
		mul_b  = y_q;
		mul_en = 1'b1;
		case (cmd.op)
			mbe_pkg::OP_MUL_RE: begin
				mul_a = W'(dcol);
				mul_b = $signed({1'b0, pixel_step_q});
			end
			mbe_pkg::OP_MUL_IM: begin
				mul_a = W'(drow);
				mul_b = $signed({1'b0, pixel_step_q});
			end
			mbe_pkg::OP_ITER_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			mbe_pkg::OP_ITER_SQX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			mbe_pkg::OP_ITER_SQY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Saturated sums and scaled products of the current cycle.
	always_comb begin
		prod_sat = mbe_pkg::sat_word(SW'(prod_q));
		next_x   = mbe_pkg::sat_word(SW'(c_re_q) + SW'(x2_q) - SW'(y2_q));
		next_y   = mbe_pkg::sat_word(SW'(c_im_q) + SW'(prod_q >>> (mbe_pkg::FRAC_BITS - 1)));
		sq_word  = mbe_pkg::sat_word(SW'(prod_q >>> mbe_pkg::FRAC_BITS));
		mag_sq   = mbe_pkg::sat_word(SW'(x2_q) + SW'(y2_q));
		limit    = (max_iter_q < mbe_pkg::ITER_LIMIT) ? max_iter_q : mbe_pkg::ITER_LIMIT;
	end

	// Shared multiplier with a registered product.
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Pixel capture, point setup and the iteration registers.
	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			col_q <= column;
			row_q <= pixel_row;
		end
		case (cmd.op)
			mbe_pkg::OP_MUL_IM: begin
				c_re_q <= mbe_pkg::sat_word(SW'(prod_sat) + SW'(origin_x_q));
			end
			mbe_pkg::OP_INIT: begin
				c_im_q  <= mbe_pkg::sat_word(SW'(prod_sat) + SW'(origin_y_q));
				x_q     <= '0;
				y_q     <= '0;
				x2_q    <= '0;
				y2_q    <= '0;
				count_q <= '0;
			end
			mbe_pkg::OP_ITER_XY: begin
				x_q <= next_x;
			end
			mbe_pkg::OP_ITER_SQX: begin
				y_q <= next_y;
			end
			mbe_pkg::OP_ITER_SQY: begin
				x2_q <= sq_word;
			end
			mbe_pkg::OP_ITER_ACC: begin
				y2_q    <= sq_word;
				count_q <= count_q + 1'b1;
			end
			mbe_pkg::OP_SHADE: begin
				shade_q <= quotient;
			end
			mbe_pkg::OP_ZERO_SHADE: begin
				shade_q <= '0;
			end
			default: begin
				shade_q <= shade_q;
			end
		endcase
	end

	// Shade dividend count*255, formed as count*256 - count.
	assign scaled_count = {count_q, 8'd0} - {8'd0, count_q};

	mbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == mbe_pkg::OP_DIV_START),
		.dividend (scaled_count),
		.divisor  (max_iter_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// Status back to the controller.
	always_comb begin
		status.iter_go   = (mag_sq < mbe_pkg::ESCAPE_BOUND) && (count_q < limit);
		status.count_ge2 = (count_q >= 8'd2);
		status.div_done  = div_done;
	end

	assign shade           = shade_q;
	assign iteration_count = count_q;

endmodule

// File: design/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl: sequencer of the escape-time unit
// Steps the datapath through point setup, the iteration loop, the shade
// division or a zero shade, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module mbe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mbe_pkg::dp_status_t status,
	output mbe_pkg::dp_cmd_t    cmd,
	output logic                busy,
	output logic                done
);

	mbe_pkg::ctrl_state_t state_q;
	mbe_pkg::ctrl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cmd.load_pixel = 1'b0;
		cmd.op         = mbe_pkg::OP_NONE;
		busy           = 1'b1;
		done           = 1'b0;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_pixel = 1'b1;
					state_d        = mbe_pkg::ST_MUL_RE;
				end
			end
			mbe_pkg::ST_MUL_RE: begin
				cmd.op  = mbe_pkg::OP_MUL_RE;
				state_d = mbe_pkg::ST_MUL_IM;
			end
			mbe_pkg::ST_MUL_IM: begin
				cmd.op  = mbe_pkg::OP_MUL_IM;
				state_d = mbe_pkg::ST_INIT;
			end
			mbe_pkg::ST_INIT: begin
				cmd.op  = mbe_pkg::OP_INIT;
				state_d = mbe_pkg::ST_CHECK;
			end
			mbe_pkg::ST_CHECK: begin
				if (status.iter_go) begin
					cmd.op  = mbe_pkg::OP_ITER_XY;
					state_d = mbe_pkg::ST_SQ_X;
				end else if (status.count_ge2) begin
					cmd.op  = mbe_pkg::OP_DIV_START;
					state_d = mbe_pkg::ST_DIV;
				end else begin
					cmd.op  = mbe_pkg::OP_ZERO_SHADE;
					state_d = mbe_pkg::ST_FINISH;
				end
			end
			mbe_pkg::ST_SQ_X: begin
				cmd.op  = mbe_pkg::OP_ITER_SQX;
				state_d = mbe_pkg::ST_SQ_Y;
			end
			mbe_pkg::ST_SQ_Y: begin
				cmd.op  = mbe_pkg::OP_ITER_SQY;
				state_d = mbe_pkg::ST_ACC;
			end
			mbe_pkg::ST_ACC: begin
				cmd.op  = mbe_pkg::OP_ITER_ACC;
				state_d = mbe_pkg::ST_CHECK;
			end
			mbe_pkg::ST_DIV: begin
				if (status.div_done) begin
					cmd.op  = mbe_pkg::OP_SHADE;
					state_d = mbe_pkg::ST_FINISH;
				end
			end
			mbe_pkg::ST_FINISH: begin
				done    = 1'b1;
				state_d = mbe_pkg::ST_IDLE;
			end
			default: begin
				state_d = mbe_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: bench/tb_mandelbrot_escape_time_pixel_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_pixel_unit: self-checking bench of the pixel unit
// Drives pixels through the start/busy handshake, loads the view registers
// between phases, and checks every shade and iteration count against an
// escape-time calculation kept in the bench or a result typed into the table.
// A directed table covers the register extremes, off-screen pixels and the
// zero limit; random phases with bursty pixel traffic follow.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel_unit;

	localparam longint WORD_MAX        = 64'sd2147483647;
	localparam longint WORD_MIN        = -64'sd2147483648;
	localparam longint PIX_CENTRE_COL  = 160;
	localparam longint PIX_CENTRE_ROW  = 100;
	localparam longint LOOP_CAP        = 255;
	localparam longint SHADE_FULL      = 255;
	localparam int     NUM_PHASES      = 10;
	localparam int     PIXELS_PER_PHASE = 70;
	localparam int     PRESSURE_PHASE  = 3;
	localparam int     SETTLE_CYCLES   = 1100;
	localparam longint CYCLE_LIMIT     = 4000000;

	typedef struct packed {
		logic [7:0] shade;
		logic [7:0] count;
	} pixel_result_t;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [1:0]    index;
		logic [31:0]   data;
		logic [8:0]    col;
		logic [7:0]    row;
		logic          typed;
		pixel_result_t want;
	} directed_row_t;

	localparam int NUM_DIRECTED_ROWS = 41;

	// Directed table. Rows with typed set carry a result that follows directly
	// from the registers; the others go through the escape-time calculation.
	directed_row_t directed_rows [NUM_DIRECTED_ROWS] = '{
		// Reset view: c = 0 for every pixel, runs to the limit of 32.
		'{kind: ROW_PIXEL, col: 9'd0, row: 8'd0, typed: 1'b1, want: '{8'd255, 8'd32},
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd511, row: 8'd255, typed: 1'b1, want: '{8'd255, 8'd32},
			default: '0},
		// Zero limit: no iteration at all.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_MAX_ITER, data: 32'd0, default: '0},
		'{kind: ROW_PIXEL, col: 9'd160, row: 8'd100, typed: 1'b1, want: '{8'd0, 8'd0},
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd511, row: 8'd0, typed: 1'b1, want: '{8'd0, 8'd0},
			default: '0},
		// Single iteration at the origin extremes.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_MAX_ITER, data: 32'd1, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_ORIGIN_X, data: 32'h7fff_ffff, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_ORIGIN_Y, data: 32'h8000_0000, default: '0},
		'{kind: ROW_PIXEL, col: 9'd160, row: 8'd100, typed: 1'b1, want: '{8'd0, 8'd1},
			default: '0},
		// Largest step: corner pixels saturate and escape at once.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_MAX_ITER, data: 32'd255, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_ORIGIN_X, data: 32'h0000_0000, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_ORIGIN_Y, data: 32'h0000_0000, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_PIXEL_STEP, data: 32'h7fff_ffff,
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd0, row: 8'd0, typed: 1'b1, want: '{8'd0, 8'd1},
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd511, row: 8'd255, typed: 1'b1, want: '{8'd0, 8'd1},
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd160, row: 8'd100, typed: 1'b1, want: '{8'd255, 8'd255},
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd161, row: 8'd100, default: '0},
		// The top bit of the step word is not part of the register.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_PIXEL_STEP, data: 32'hffff_ffff,
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd159, row: 8'd99, default: '0},
		// Points on the boundary of the set: exactly four and the cusp.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_PIXEL_STEP, data: 32'h0000_0000,
			default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_ORIGIN_X, data: 32'he000_0000, default: '0},
		'{kind: ROW_PIXEL, col: 9'd0, row: 8'd0, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_ORIGIN_X, data: 32'h0400_0000, default: '0},
		'{kind: ROW_PIXEL, col: 9'd10, row: 8'd10, default: '0},
		// Usual full-set view around -0.5.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_MAX_ITER, data: 32'd100, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_ORIGIN_X, data: 32'hf800_0000, default: '0},
		'{kind: ROW_WRITE, index: mbe_pkg::REG_PIXEL_STEP, data: 32'h003d_70a4,
			default: '0},
		'{kind: ROW_PIXEL, col: 9'd160, row: 8'd100, default: '0},
		'{kind: ROW_PIXEL, col: 9'd0, row: 8'd0, default: '0},
		'{kind: ROW_PIXEL, col: 9'd319, row: 8'd239, default: '0},
		'{kind: ROW_PIXEL, col: 9'd100, row: 8'd120, default: '0},
		'{kind: ROW_PIXEL, col: 9'd200, row: 8'd80, default: '0},
		'{kind: ROW_PIXEL, col: 9'd250, row: 8'd100, default: '0},
		'{kind: ROW_PIXEL, col: 9'd60, row: 8'd40, default: '0},
		// A limit that does not divide 255 evenly.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_MAX_ITER, data: 32'd7, default: '0},
		'{kind: ROW_PIXEL, col: 9'd120, row: 8'd100, default: '0},
		'{kind: ROW_PIXEL, col: 9'd150, row: 8'd130, default: '0},
		'{kind: ROW_PIXEL, col: 9'd300, row: 8'd20, default: '0},
		// Count of exactly two, and a pixel with the top bits of column and row set.
		'{kind: ROW_WRITE, index: mbe_pkg::REG_MAX_ITER, data: 32'd2, default: '0},
		'{kind: ROW_PIXEL, col: 9'd160, row: 8'd100, default: '0},
		'{kind: ROW_PIXEL, col: 9'd256, row: 8'd128, default: '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = mbe_pkg::REG_MAX_ITER;
	logic [31:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [8:0]  column = '0;
	logic [7:0]  pixel_row = '0;
	logic        done;
	logic [7:0]  shade;
	logic [7:0]  iteration_count;

	// Bench copy of the view registers, updated on every write transfer.
	logic [7:0]         max_iter_q = 8'd32;
	logic signed [31:0] origin_x_q = '0;
	logic signed [31:0] origin_y_q = '0;
	logic [30:0]        step_q = '0;

	// Result the sender attaches to the pixel it is offering.
	logic          offer_typed = 1'b0;
	pixel_result_t offer_result = '0;

	pixel_result_t pending_pixels [$];
	int            mismatch_count = 0;
	longint        cycle_count = 0;

	mandelbrot_escape_time_pixel_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.column          (column),
		.pixel_row       (pixel_row),
		.done            (done),
		.shade           (shade),
		.iteration_count (iteration_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamp to the signed 32-bit word range.
	function automatic longint clamp_q428(input longint v);
		if (v > WORD_MAX) begin
			return WORD_MAX;
		end else if (v < WORD_MIN) begin
			return WORD_MIN;
		end
		return v;
	endfunction

	// Escape-time count and shade of one pixel under the current view.
	function automatic pixel_result_t escape_time(input logic [8:0] col, input logic [7:0] row);
		longint c_re;
		longint c_im;
		longint x;
		longint y;
		longint x2;
		longint y2;
		longint nx;
		longint ny;
		longint four;
		longint limit;
		longint count;
		longint grey;
		pixel_result_t res;
		four  = 64'sd4 <<< mbe_pkg::FRAC_BITS;
		limit = (longint'(max_iter_q) < LOOP_CAP) ? longint'(max_iter_q) : LOOP_CAP;
		c_re  = clamp_q428(clamp_q428((longint'(col) - PIX_CENTRE_COL) * longint'(step_q))
			+ longint'(origin_x_q));
		c_im  = clamp_q428(clamp_q428((longint'(row) - PIX_CENTRE_ROW) * longint'(step_q))
			+ longint'(origin_y_q));
		x = 0;
		y = 0;
		x2 = 0;
		y2 = 0;
		count = 0;
		// The imaginary update uses the real part from before this iteration.
		while (clamp_q428(x2 + y2) < four && count < limit) begin
			ny = clamp_q428(c_im + ((x * y) >>> (mbe_pkg::FRAC_BITS - 1)));
			nx = clamp_q428(c_re + x2 - y2);
			x  = nx;
			y  = ny;
			x2 = clamp_q428((x * x) >>> mbe_pkg::FRAC_BITS);
			y2 = clamp_q428((y * y) >>> mbe_pkg::FRAC_BITS);
			count++;
		end
		grey = 0;
		if (count >= 2 && max_iter_q != 0) begin
			grey = (count * SHADE_FULL) / longint'(max_iter_q);
		end
		res.shade = grey[7:0];
		res.count = count[7:0];
		return res;
	endfunction

	// Random register contents; unused high bits of the write data are random too.
	function automatic logic [31:0] random_reg_value(input logic [1:0] idx);
		logic [31:0] value;
		int          pick;
		pick = $urandom_range(0, 9);
		value = '0;
		case (idx)
			mbe_pkg::REG_MAX_ITER: begin
				if (pick == 0) begin
					value = 32'd0;
				end else if (pick == 1) begin
					value = 32'd255;
				end else if (pick == 2) begin
					value = 32'd1;
				end else if (pick < 5) begin
					value = $urandom_range(0, 255);
				end else begin
					value = $urandom_range(2, 48);
				end
				value = ($urandom & 32'hffff_ff00) | value;
			end
			mbe_pkg::REG_ORIGIN_X: begin
				if (pick == 0) begin
					value = $urandom;
				end else begin
					value = 32'($urandom_range(0, 805306368)) - 32'd603979776;
				end
			end
			mbe_pkg::REG_ORIGIN_Y: begin
				if (pick == 0) begin
					value = $urandom;
				end else begin
					value = 32'($urandom_range(0, 671088640)) - 32'd335544320;
				end
			end
			mbe_pkg::REG_PIXEL_STEP: begin
				if (pick == 0) begin
					value = $urandom;
				end else if (pick == 1) begin
					value = ($urandom & 32'h8000_0000);
				end else begin
					value = ($urandom >> $urandom_range(8, 24)) | ($urandom & 32'h8000_0000);
				end
			end
			default: value = $urandom;
		endcase
		return value;
	endfunction

	// Register write transfer; drops cfg_we again and leaves the port quiet before returning.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one pixel and hold it until the unit takes it; returns at a falling edge.
	task automatic send_pixel(input logic [8:0] col, input logic [7:0] row,
		input logic typed, input pixel_result_t want);
		column       <= col;
		pixel_row    <= row;
		start        <= 1'b1;
		offer_typed  = typed;
		offer_result = want;
		do begin
			@(posedge clk);
		end while (busy);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every pixel in flight has reported back.
	task automatic wait_until_idle();
		start <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending_pixels.size() != 0 || busy);
	endtask

	// Shadow registers, expectation store and result check.
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_pixels.size() == 0) begin
					$error("result with no pixel pending: shade %0d, iteration_count %0d",
						shade, iteration_count);
					mismatch_count++;
				end else begin
					want = pending_pixels.pop_front();
					if (shade !== want.shade) begin
						$error("shade: expected %0d, actual %0d", want.shade, shade);
						mismatch_count++;
					end
					if (iteration_count !== want.count) begin
						$error("iteration_count: expected %0d, actual %0d",
							want.count, iteration_count);
						mismatch_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					mbe_pkg::REG_MAX_ITER:   max_iter_q = cfg_data[7:0];
					mbe_pkg::REG_ORIGIN_X:   origin_x_q = cfg_data;
					mbe_pkg::REG_ORIGIN_Y:   origin_y_q = cfg_data;
					mbe_pkg::REG_PIXEL_STEP: step_q = cfg_data[30:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (offer_typed) begin
					pending_pixels.push_back(offer_result);
				end else begin
					pending_pixels.push_back(escape_time(column, pixel_row));
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_mandelbrot_escape_time_pixel_unit: done, errors");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		logic [1:0]  reg_idx;
		logic [8:0]  col;
		logic [7:0]  row;
		int          first;
		int          burst_left;
		int          gap_pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_until_idle();
				write_reg(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_pixel(directed_rows[i].col, directed_rows[i].row,
					directed_rows[i].typed, directed_rows[i].want);
				idle_gap($urandom_range(0, 3));
			end
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// New view, every register written, in a rotating order.
			wait_until_idle();
			first = $urandom_range(0, 3);
			for (int k = 0; k < 4; k++) begin
				reg_idx = 2'(first + k);
				write_reg(reg_idx, random_reg_value(reg_idx));
			end
			burst_left = 0;
			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				if ((phase == PRESSURE_PHASE && n == PIXELS_PER_PHASE / 2)
					|| $urandom_range(0, 39) == 0) begin
					wait_until_idle();
				end
				if ($urandom_range(0, 9) == 0) begin
					col = $urandom_range(0, 511);
					row = $urandom_range(0, 255);
				end else begin
					col = $urandom_range(0, 319);
					row = $urandom_range(0, 239);
				end
				send_pixel(col, row, 1'b0, '0);
				// Bursts of back-to-back offers separated by gaps of varied length.
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_pick = $urandom_range(0, 7);
					if (gap_pick < 3) begin
						idle_gap(0);
					end else if (gap_pick == 7) begin
						idle_gap($urandom_range(20, 300));
					end else begin
						idle_gap($urandom_range(1, 12));
					end
				end else begin
					burst_left--;
				end
			end
		end

		wait_until_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0) begin
			$display("tb_mandelbrot_escape_time_pixel_unit: done, clean");
		end else begin
			$display("tb_mandelbrot_escape_time_pixel_unit: done, errors");
		end
		$finish;
	end

endmodule

// File: mandelbrot_escape_time_pixel_unit.f
design/mbe_pkg.sv
design/mbe_div.sv
design/mbe_dp.sv
design/mbe_ctrl.sv
design/mandelbrot_escape_time_pixel_unit.sv
bench/tb_mandelbrot_escape_time_pixel_unit.sv
